[hw/rtl/dss_pkg.sv]
// Shared types, codes and the deadline ordering function of the deadline
// spread scheduler. No dependencies; the cells, the top level and the testbench import it.
package dss_pkg;

  localparam int unsigned SLOTS_DEF   = 16;
  localparam int unsigned MAX_SLOTS   = 64;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned MAX_RESULTS = 16;

  localparam logic [2:0] CMD_CREATE   = 3'd0;
  localparam logic [2:0] CMD_RELEASE  = 3'd1;
  localparam logic [2:0] CMD_SCHEDULE = 3'd2;
  localparam logic [2:0] CMD_QUERY    = 3'd3;
  localparam logic [2:0] CMD_TICK     = 3'd4;

  localparam logic [2:0] STS_NOT_SCHEDULED = 3'd0;
  localparam logic [2:0] STS_SUPERSEDED    = 3'd4;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_FULL     = 2'd1;
  localparam logic [1:0] ERR_NOT_USED = 2'd2;

  typedef enum logic [1:0] {
    JS_NOT_SCHEDULED = 2'd0,
    JS_PENDING       = 2'd1,
    JS_RUNNING       = 2'd2,
    JS_COMPLETE      = 2'd3
  } job_state_t;

  typedef enum logic [2:0] {
    SOP_NONE,
    SOP_CREATE,
    SOP_RELEASE,
    SOP_SCHEDULE,
    SOP_COMPLETE,
    SOP_RUN
  } slot_op_t;

  typedef struct packed {
    slot_op_t         op;
    logic [IDX_W-1:0] target;
    logic [7:0]       delay;
    logic [31:0]      tick;
  } slot_ctl_t;

  typedef struct packed {
    logic        in_use;
    logic [15:0] gen;
    job_state_t  state;
    logic [7:0]  delay;
    logic [31:0] since;
  } slot_view_t;

  typedef struct packed {
    logic             valid;
    logic [31:0]      deadline;
    logic [31:0]      since;
    logic [IDX_W-1:0] slot;
  } sort_ent_t;

  typedef enum logic [1:0] {
    SRT_HOLD,
    SRT_CLEAR,
    SRT_INSERT,
    SRT_SHIFT
  } sort_op_t;

  typedef struct packed {
    sort_op_t  op;
    sort_ent_t key;
  } sort_ctl_t;

  // True when job a must start ahead of job b.
  function automatic logic key_before(sort_ent_t a, sort_ent_t b);
    logic r;
    if (a.deadline != b.deadline) begin
      r = a.deadline < b.deadline;
    end else if (a.since != b.since) begin
      r = a.since < b.since;
    end else begin
      r = a.slot < b.slot;
    end
    return r;
  endfunction

endpackage

[hw/rtl/dss_in_if.sv]
// Command channel of the deadline spread scheduler: valid/ready plus the
// command payload. Stands alone; used by the top level.
interface dss_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [3:0]  slot;
  logic [7:0]  max_delay;
  logic [15:0] token_generation;
  logic        has_token;

  modport source (output valid, command, slot, max_delay, token_generation, has_token,
                  input ready);
  modport sink (input valid, command, slot, max_delay, token_generation, has_token,
                output ready);
endinterface

[hw/rtl/dss_out_if.sv]
// Result channel of the deadline spread scheduler: valid/ready plus one
// result beat. Stands alone; used by the top level.
interface dss_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  result_slot;
  logic [15:0] result_generation;
  logic [2:0]  job_status;
  logic [1:0]  error;
  logic        started;
  logic        last;

  modport source (output valid, result_slot, result_generation, job_status, error,
                  started, last, input ready);
  modport sink (input valid, result_slot, result_generation, job_status, error,
                started, last, output ready);
endinterface

[hw/rtl/dss_slot_cell.sv]
// One job slot of the scheduler table: use flag, generation, job state,
// delay and pending tick. Depends on dss_pkg.
module dss_slot_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dss_pkg::slot_ctl_t ctl,
  output dss_pkg::slot_view_t view
);
  import dss_pkg::*;

  logic        in_use_r;
  logic [15:0] gen_r;
  job_state_t  state_r;
  logic [7:0]  delay_r;
  logic [31:0] since_r;
  logic        hit;

  assign hit = (ctl.target == IDX_W'(IDX));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= 1'b0;
      gen_r    <= '0;
      state_r  <= JS_NOT_SCHEDULED;
    end else begin
      unique case (ctl.op)
        SOP_CREATE: if (hit) begin
          in_use_r <= 1'b1;
          state_r  <= JS_NOT_SCHEDULED;
        end
        SOP_RELEASE: if (hit) begin
          in_use_r <= 1'b0;
          gen_r    <= gen_r + 16'd1;
          state_r  <= JS_NOT_SCHEDULED;
        end
        SOP_SCHEDULE: if (hit) begin
          gen_r   <= gen_r + 16'd1;
          state_r <= JS_PENDING;
        end
        SOP_COMPLETE: if (in_use_r && state_r == JS_RUNNING) begin
          state_r <= JS_COMPLETE;
        end
        SOP_RUN: if (hit) begin
          state_r <= JS_RUNNING;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (hit && ctl.op == SOP_CREATE) begin
      delay_r <= (ctl.delay == 8'd0) ? 8'd1 : ctl.delay;
    end
    if (hit && ctl.op == SOP_SCHEDULE) begin
      since_r <= ctl.tick;
    end
  end

  assign view = '{in_use: in_use_r, gen: gen_r, state: state_r,
                  delay: delay_r, since: since_r};
endmodule

[hw/rtl/dss_sort_cell.sv]
// One place of the insertion sort chain that orders pending jobs by
// deadline, pending tick and slot. Depends on dss_pkg.
module dss_sort_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  dss_pkg::sort_ctl_t ctl,
  input  dss_pkg::sort_ent_t prev_ent,
  input  logic               prev_lt,
  input  dss_pkg::sort_ent_t next_ent,
  output dss_pkg::sort_ent_t ent,
  output logic               lt
);
  import dss_pkg::*;

  sort_ent_t ent_r;

  // The chain is sorted, so lt is false up to the insertion point and true after it.
  assign lt  = !ent_r.valid || key_before(ctl.key, ent_r);
  assign ent = ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else begin
      unique case (ctl.op)
        SRT_CLEAR:  ent_r <= '0;
        SRT_INSERT: if (lt) begin
          ent_r <= prev_lt ? prev_ent : ctl.key;
        end
        SRT_SHIFT:  ent_r <= next_ent;
        default:    ;
      endcase
    end
  end
endmodule

[hw/rtl/deadline_spread_scheduler.sv]
// Deadline spread scheduler: a table of SLOTS job slots taking create,
// release, schedule, query and tick commands. Commands other than tick give
// one beat. On a tick the pending jobs enter a sorted chain one slot per
// cycle, the chain is rotated once to find the run count, then the started
// jobs leave it one beat a cycle while the output channel is free.
// Depends on dss_pkg, dss_in_if, dss_out_if, dss_slot_cell, dss_sort_cell.
module deadline_spread_scheduler #(
  parameter int unsigned SLOTS = dss_pkg::SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dss_in_if.sink    in_ch,
  dss_out_if.source out_ch
);
  import dss_pkg::*;

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {S_IDLE, S_CMD, S_FEED, S_RUNCALC, S_EMIT} state_t;

  state_t      state_r;
  logic [2:0]  cmd_r;
  logic [3:0]  slot_r;
  logic [7:0]  delay_r;
  logic [15:0] tgen_r;
  logic        has_r;
  logic [31:0] tick_r;
  logic [SW-1:0] scan_r;
  logic [SW-1:0] rot_r;
  logic [CW-1:0] run_r;
  logic [CW-1:0] e_r;

  logic        out_valid_r;
  logic [3:0]  o_slot_r;
  logic [15:0] o_gen_r;
  logic [2:0]  o_status_r;
  logic [1:0]  o_err_r;
  logic        o_started_r;
  logic        o_last_r;

  slot_ctl_t   sctl;
  slot_view_t  views [SLOTS];
  sort_ctl_t   tctl;
  sort_ent_t   ents [SLOTS];
  logic        lts [SLOTS];

  for (genvar g = 0; g < SLOTS; g++) begin : g_slot
    dss_slot_cell #(.IDX(g)) u_cell (.clk(clk), .rst_n(rst_n), .ctl(sctl), .view(views[g]));
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_sort
    sort_ent_t nxt;
    if (g == SLOTS - 1) begin : g_end
      assign nxt = (state_r == S_RUNCALC) ? ents[0] : '0;
    end else begin : g_mid
      assign nxt = ents[g+1];
    end
    if (g == 0) begin : g_head
      dss_sort_cell u_cell (.clk(clk), .rst_n(rst_n), .ctl(tctl), .prev_ent('0),
                            .prev_lt(1'b0), .next_ent(nxt), .ent(ents[g]), .lt(lts[g]));
    end else begin : g_body
      dss_sort_cell u_cell (.clk(clk), .rst_n(rst_n), .ctl(tctl), .prev_ent(ents[g-1]),
                            .prev_lt(lts[g-1]), .next_ent(nxt), .ent(ents[g]), .lt(lts[g]));
    end
  end

  // Addressed slot and lowest free slot.
  logic [IDX_W-1:0] tgt;
  slot_view_t       sel;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  always_comb begin
    tgt        = IDX_W'(slot_r);
    sel        = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (IDX_W'(i) == tgt) begin
        sel = views[i];
      end
      if (!free_found && !views[i].in_use) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // Answer beat of a command other than tick.
  logic [3:0]  cb_slot;
  logic [15:0] cb_gen;
  logic [2:0]  cb_status;
  logic [1:0]  cb_err;
  always_comb begin
    cb_slot   = '0;
    cb_gen    = '0;
    cb_status = STS_NOT_SCHEDULED;
    cb_err    = ERR_NONE;
    unique case (cmd_r)
      CMD_CREATE: begin
        if (free_found) begin
          cb_slot = free_idx[3:0];
        end else begin
          cb_err = ERR_FULL;
        end
      end
      CMD_RELEASE: begin
        cb_slot = slot_r;
        if (!sel.in_use) begin
          cb_err = ERR_NOT_USED;
        end
      end
      CMD_SCHEDULE: begin
        cb_slot = slot_r;
        if (sel.in_use) begin
          cb_gen = sel.gen + 16'd1;
        end else begin
          cb_err = ERR_NOT_USED;
        end
      end
      CMD_QUERY: begin
        cb_slot = slot_r;
        if (!has_r) begin
          cb_status = STS_NOT_SCHEDULED;
        end else if (!sel.in_use || sel.gen != tgen_r) begin
          cb_status = STS_SUPERSEDED;
        end else begin
          cb_status = {1'b0, sel.state};
        end
      end
      default: ;
    endcase
  end

  // Scan read and rotation head arithmetic.
  slot_view_t      sv;
  sort_ent_t       head;
  logic [31:0]     diff;
  logic [CW-1:0]   leftcap;
  logic [2*CW-1:0] prod;
  logic            need_more;
  always_comb begin
    sv   = views[scan_r];
    head = ents[0];
    diff = head.deadline - tick_r;
    if (diff[31]) begin
      leftcap = CW'(1);
    end else if (diff >= 32'(SLOTS - 1)) begin
      leftcap = CW'(SLOTS);
    end else begin
      leftcap = CW'(diff + 32'd1);
    end
    prod      = (2*CW)'(run_r) * (2*CW)'(leftcap);
    need_more = head.valid && (run_r == '0 || (2*CW)'(rot_r) >= prod);
  end

  logic out_free;
  logic beat_load;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    sctl      = '{op: SOP_NONE, target: tgt, delay: delay_r, tick: tick_r};
    tctl      = '{op: SRT_HOLD, key: '0};
    beat_load = 1'b0;
    unique case (state_r)
      S_CMD: begin
        if (cmd_r == CMD_TICK) begin
          sctl.op = SOP_COMPLETE;
          tctl.op = SRT_CLEAR;
        end else if (out_free) begin
          beat_load = 1'b1;
          if (cmd_r == CMD_CREATE && free_found) begin
            sctl.op     = SOP_CREATE;
            sctl.target = free_idx;
          end else if (cmd_r == CMD_RELEASE && sel.in_use) begin
            sctl.op = SOP_RELEASE;
          end else if (cmd_r == CMD_SCHEDULE && sel.in_use) begin
            sctl.op = SOP_SCHEDULE;
          end
        end
      end
      S_FEED: begin
        tctl.key = '{valid: 1'b1, deadline: sv.since + {24'd0, sv.delay},
                     since: sv.since, slot: IDX_W'(scan_r)};
        if (sv.in_use && sv.state == JS_PENDING) begin
          tctl.op = SRT_INSERT;
        end
      end
      S_RUNCALC: begin
        if (!need_more) begin
          tctl.op = SRT_SHIFT;
        end
      end
      S_EMIT: begin
        if (run_r == '0) begin
          beat_load = out_free;
        end else if (e_r != run_r &&
                     (32'(e_r) >= 32'(MAX_RESULTS) || out_free)) begin
          sctl.op     = SOP_RUN;
          sctl.target = head.slot;
          tctl.op     = SRT_SHIFT;
          beat_load   = 32'(e_r) < 32'(MAX_RESULTS);
        end
      end
      default: ;
    endcase
  end

  // A new beat may be loaded in the cycle the previous one is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (beat_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= '0;
      scan_r      <= '0;
      rot_r       <= '0;
      run_r       <= '0;
      e_r         <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd_r   <= in_ch.command;
            slot_r  <= in_ch.slot;
            delay_r <= in_ch.max_delay;
            tgen_r  <= in_ch.token_generation;
            has_r   <= in_ch.has_token;
            state_r <= S_CMD;
          end
        end
        S_CMD: begin
          if (cmd_r == CMD_TICK) begin
            tick_r  <= tick_r + 32'd1;
            scan_r  <= '0;
            state_r <= S_FEED;
          end else if (out_free) begin
            o_slot_r    <= cb_slot;
            o_gen_r     <= cb_gen;
            o_status_r  <= cb_status;
            o_err_r     <= cb_err;
            o_started_r <= 1'b0;
            o_last_r    <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_FEED: begin
          scan_r <= scan_r + SW'(1);
          if (scan_r == SW'(SLOTS - 1)) begin
            rot_r   <= '0;
            run_r   <= '0;
            state_r <= S_RUNCALC;
          end
        end
        S_RUNCALC: begin
          if (need_more) begin
            run_r <= run_r + CW'(1);
          end else begin
            rot_r <= rot_r + SW'(1);
            if (rot_r == SW'(SLOTS - 1)) begin
              e_r     <= '0;
              state_r <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (run_r == '0) begin
            if (out_free) begin
              o_slot_r    <= '0;
              o_gen_r     <= '0;
              o_status_r  <= STS_NOT_SCHEDULED;
              o_err_r     <= ERR_NONE;
              o_started_r <= 1'b0;
              o_last_r    <= 1'b1;
              state_r     <= S_IDLE;
            end
          end else if (e_r == run_r) begin
            state_r <= S_IDLE;
          end else if (32'(e_r) >= 32'(MAX_RESULTS)) begin
            // Jobs past the reported limit still start, without a beat.
            e_r <= e_r + CW'(1);
          end else if (out_free) begin
            o_slot_r    <= head.slot[3:0];
            o_gen_r     <= '0;
            o_status_r  <= STS_NOT_SCHEDULED;
            o_err_r     <= ERR_NONE;
            o_started_r <= 1'b1;
            o_last_r    <= (32'(e_r) + 32'd1 == 32'(run_r)) ||
                           (32'(e_r) == 32'(MAX_RESULTS - 1));
            e_r         <= e_r + CW'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.result_slot       = o_slot_r;
  assign out_ch.result_generation = o_gen_r;
  assign out_ch.job_status        = o_status_r;
  assign out_ch.error             = o_err_r;
  assign out_ch.started           = o_started_r;
  assign out_ch.last              = o_last_r;
endmodule

[test/deadline_spread_scheduler_tb.sv]
// Self-checking testbench of deadline_spread_scheduler: a directed and a random
// command stream, predicted in the bench and checked beat by beat.
// Depends on dss_pkg, dss_in_if, dss_out_if and the RTL of the scheduler.
`timescale 1ns / 1ps
module deadline_spread_scheduler_tb;
  import dss_pkg::*;

  localparam int unsigned NSLOT = 16;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam logic [2:0] STS_PENDING  = 3'd1;
  localparam logic [2:0] STS_RUNNING  = 3'd2;
  localparam logic [2:0] STS_COMPLETE = 3'd3;
  localparam logic [2:0] CMD_BAD5 = 3'd5;
  localparam logic [2:0] CMD_BAD7 = 3'd7;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  slot;
    logic [7:0]  max_delay;
    logic [15:0] token_generation;
    logic        has_token;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  slot;
    logic [15:0] gen;
    logic [2:0]  status;
    logic [1:0]  err;
    logic        started;
    logic        last;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  dss_in_if  in_ch ();
  dss_out_if out_ch ();

  deadline_spread_scheduler #(.SLOTS(NSLOT)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the job table.
  logic        busy [NSLOT];
  logic [7:0]  delay_tab [NSLOT];
  logic [31:0] since_tab [NSLOT];
  logic [15:0] gen_tab [NSLOT];
  job_state_t  state_tab [NSLOT];
  logic [31:0] frame_now;

  cmd_t  pend_q [$];
  beat_t expect_q [$];
  int    fails = 0;
  int    sent = 0;
  int    beats = 0;
  int    starts = 0;
  int    ticks = 0;
  bit    no_idle = 1'b0;

  function automatic void add_beat(beat_t b);
    expect_q.insert(expect_q.size(), b);
  endfunction

  function automatic void add_cmd(cmd_t c);
    pend_q.insert(pend_q.size(), c);
  endfunction

  function automatic beat_t mk(logic [3:0] s, logic [15:0] g, logic [2:0] st,
                               logic [1:0] e, logic sb, logic lb);
    beat_t b;
    b.slot = s; b.gen = g; b.status = st; b.err = e; b.started = sb; b.last = lb;
    return b;
  endfunction

  function automatic bit runs_first(int a, int b);
    logic [31:0] da, db;
    da = since_tab[a] + 32'(delay_tab[a]);
    db = since_tab[b] + 32'(delay_tab[b]);
    if (da != db) return da < db;
    if (since_tab[a] != since_tab[b]) return since_tab[a] < since_tab[b];
    return a < b;
  endfunction

  task automatic advance_frame();
    int order [NSLOT];
    int n, j, runs, k;
    logic [31:0] diff;
    longint unsigned left, need;
    n = 0; runs = 0; k = 0;
    frame_now = frame_now + 32'd1;
    ticks++;
    for (int i = 0; i < NSLOT; i++) begin
      if (busy[i] && state_tab[i] == JS_PENDING) begin
        j = n;
        while (j > 0 && runs_first(i, order[j-1])) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
        n++;
      end
    end
    for (int q = 0; q < n; q++) begin
      diff = since_tab[order[q]] + 32'(delay_tab[order[q]]) - frame_now;
      left = diff[31] ? 64'd1 : 64'(diff) + 64'd1;
      need = (64'(q) + left) / left;
      if (need > 64'(runs)) runs = int'(need);
    end
    for (int i = 0; i < NSLOT; i++)
      if (busy[i] && state_tab[i] == JS_RUNNING) state_tab[i] = JS_COMPLETE;
    for (int q = 0; q < runs; q++) begin
      state_tab[order[q]] = JS_RUNNING;
      if (k < MAX_RESULTS) begin
        add_beat(mk(4'(order[q]), '0, '0, ERR_NONE, 1'b1, 1'b0));
        k++;
      end
    end
    starts += runs;
    if (k == 0) add_beat(mk('0, '0, '0, ERR_NONE, 1'b0, 1'b1));
    else expect_q[$].last = 1'b1;
  endtask

  task automatic apply_command(cmd_t c);
    bit ok, found;
    logic [2:0] st;
    ok = busy[c.slot];
    found = 1'b0;
    case (c.command)
      CMD_CREATE: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (!found && !busy[i]) begin
            found = 1'b1;
            busy[i] = 1'b1;
            delay_tab[i] = (c.max_delay == 0) ? 8'd1 : c.max_delay;
            state_tab[i] = JS_NOT_SCHEDULED;
            add_beat(mk(4'(i), '0, '0, ERR_NONE, 1'b0, 1'b1));
          end
        end
        if (!found) add_beat(mk('0, '0, '0, ERR_FULL, 1'b0, 1'b1));
      end
      CMD_RELEASE: begin
        if (ok) begin
          busy[c.slot] = 1'b0;
          gen_tab[c.slot] = gen_tab[c.slot] + 16'd1;
          state_tab[c.slot] = JS_NOT_SCHEDULED;
        end
        add_beat(mk(c.slot, '0, '0, ok ? ERR_NONE : ERR_NOT_USED, 1'b0, 1'b1));
      end
      CMD_SCHEDULE: begin
        if (ok) begin
          gen_tab[c.slot] = gen_tab[c.slot] + 16'd1;
          state_tab[c.slot] = JS_PENDING;
          since_tab[c.slot] = frame_now;
        end
        add_beat(mk(c.slot, ok ? gen_tab[c.slot] : 16'd0, '0,
                    ok ? ERR_NONE : ERR_NOT_USED, 1'b0, 1'b1));
      end
      CMD_QUERY: begin
        if (!c.has_token) st = STS_NOT_SCHEDULED;
        else if (!ok || gen_tab[c.slot] != c.token_generation) st = STS_SUPERSEDED;
        else st = {1'b0, state_tab[c.slot]};
        add_beat(mk(c.slot, '0, st, ERR_NONE, 1'b0, 1'b1));
      end
      CMD_TICK: advance_frame();
      default: add_beat(mk('0, '0, '0, ERR_NONE, 1'b0, 1'b1));
    endcase
  endtask

  function automatic cmd_t mkcmd(logic [2:0] op, logic [3:0] s, logic [7:0] d,
                                 logic [15:0] g, logic h);
    cmd_t c;
    c.command = op; c.slot = s; c.max_delay = d; c.token_generation = g; c.has_token = h;
    return c;
  endfunction

  // Driver: one item offered at a time, with a random gap (none while no_idle is set) before the next.
  int gap_left = 0;
  cmd_t cur;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.command <= '0;
      in_ch.slot <= '0;
      in_ch.max_delay <= '0;
      in_ch.token_generation <= '0;
      in_ch.has_token <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_command(cur);
        sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          cur = pend_q.pop_front();
          in_ch.command <= cur.command;
          in_ch.slot <= cur.slot;
          in_ch.max_delay <= cur.max_delay;
          in_ch.token_generation <= cur.token_generation;
          in_ch.has_token <= cur.has_token;
          in_ch.valid <= 1'b1;
          gap_left = no_idle ? 0 : $urandom_range(0, 7);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stall per beat (none while no_idle is set), plus one long hold-off to back up the block.
  int stall_left = 0;
  bit held = 1'b0;
  beat_t got, want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = mk(out_ch.result_slot, out_ch.result_generation, out_ch.job_status,
                 out_ch.error, out_ch.started, out_ch.last);
        beats++;
        if (expect_q.size() == 0) begin
          $error("unexpected beat: slot %0d", got.slot);
          fails++;
        end else begin
          want = expect_q.pop_front();
          if (got.slot != want.slot) begin
            $error("result_slot: expected %0d, got %0d", want.slot, got.slot); fails++;
          end
          if (got.gen != want.gen) begin
            $error("result_generation: expected %0d, got %0d", want.gen, got.gen); fails++;
          end
          if (got.status != want.status) begin
            $error("job_status: expected %0d, got %0d", want.status, got.status); fails++;
          end
          if (got.err != want.err) begin
            $error("error: expected %0d, got %0d", want.err, got.err); fails++;
          end
          if (got.started != want.started) begin
            $error("started: expected %0d, got %0d", want.started, got.started); fails++;
          end
          if (got.last != want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last); fails++;
          end
        end
        if (!held && beats >= 60) begin
          held = 1'b1;
          stall_left = 400;
        end else begin
          stall_left = no_idle ? 0 : $urandom_range(0, 7);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic [3:0] pick_slot();
    int live [$];
    for (int i = 0; i < NSLOT; i++) if (busy[i]) live.insert(live.size(), i);
    if (live.size() == 0 || $urandom_range(0, 9) == 0) return 4'($urandom_range(0, 15));
    return 4'(live[$urandom_range(0, live.size() - 1)]);
  endfunction

  function automatic cmd_t random_cmd();
    int w;
    logic [3:0] s;
    logic [15:0] g;
    logic [7:0] d;
    w = $urandom_range(0, 99);
    s = pick_slot();
    d = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 6));
    g = gen_tab[s];
    if ($urandom_range(0, 4) == 0) g = 16'($urandom);
    else if ($urandom_range(0, 4) == 0) g = g - 16'd1;
    if (w < 15) return mkcmd(CMD_CREATE, s, d, g, 1'b1);
    if (w < 23) return mkcmd(CMD_RELEASE, s, d, g, 1'b1);
    if (w < 53) return mkcmd(CMD_SCHEDULE, s, d, g, 1'b1);
    if (w < 75) return mkcmd(CMD_QUERY, s, d, g, $urandom_range(0, 9) != 0);
    if (w < 97) return mkcmd(CMD_TICK, s, d, g, 1'b1);
    return mkcmd(3'($urandom_range(5, 7)), s, d, 16'($urandom), 1'($urandom));
  endfunction

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      busy[i] = 1'b0; gen_tab[i] = '0; state_tab[i] = JS_NOT_SCHEDULED;
      delay_tab[i] = '0; since_tab[i] = '0;
    end
    frame_now = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: delay extremes, errors on free slots, token cases, unknown codes,
    // a full table, and a burst of starts in one frame.
    add_cmd(mkcmd(CMD_CREATE, 4'd0, 8'd0, '0, 1'b0));
    add_cmd(mkcmd(CMD_CREATE, 4'd0, 8'd255, '0, 1'b0));
    add_cmd(mkcmd(CMD_CREATE, 4'd0, 8'd1, '0, 1'b0));
    add_cmd(mkcmd(CMD_SCHEDULE, 4'd0, '0, '0, 1'b0));
    add_cmd(mkcmd(CMD_SCHEDULE, 4'd1, '0, '0, 1'b0));
    add_cmd(mkcmd(CMD_SCHEDULE, 4'd2, '0, '0, 1'b0));
    add_cmd(mkcmd(CMD_SCHEDULE, 4'd2, '0, '0, 1'b0));
    add_cmd(mkcmd(CMD_QUERY, 4'd0, '0, 16'd1, 1'b1));
    add_cmd(mkcmd(CMD_QUERY, 4'd2, '0, 16'd1, 1'b1));
    add_cmd(mkcmd(CMD_QUERY, 4'd0, '0, 16'd1, 1'b0));
    add_cmd(mkcmd(CMD_QUERY, 4'd15, '0, 16'hFFFF, 1'b1));
    add_cmd(mkcmd(CMD_RELEASE, 4'd15, '0, '0, 1'b0));
    add_cmd(mkcmd(CMD_SCHEDULE, 4'd9, '0, '0, 1'b0));
    add_cmd(mkcmd(CMD_TICK, 4'd0, '0, '0, 1'b0));
    add_cmd(mkcmd(CMD_QUERY, 4'd0, '0, 16'd1, 1'b1));
    add_cmd(mkcmd(CMD_TICK, 4'd0, '0, '0, 1'b0));
    add_cmd(mkcmd(CMD_QUERY, 4'd0, '0, 16'd1, 1'b1));
    add_cmd(mkcmd(CMD_RELEASE, 4'd1, '0, '0, 1'b0));
    add_cmd(mkcmd(CMD_QUERY, 4'd1, '0, 16'd1, 1'b1));
    add_cmd(mkcmd(CMD_BAD5, 4'd3, 8'd7, 16'h1234, 1'b1));
    add_cmd(mkcmd(CMD_BAD7, 4'd15, 8'hFF, 16'hFFFF, 1'b1));
    for (int i = 0; i < 15; i++)
      add_cmd(mkcmd(CMD_CREATE, 4'd0, 8'(i % 4 + 1), '0, 1'b0));
    for (int i = 0; i < 16; i++)
      add_cmd(mkcmd(CMD_SCHEDULE, 4'(i), '0, '0, 1'b0));
    add_cmd(mkcmd(CMD_TICK, 4'd0, '0, '0, 1'b0));
    add_cmd(mkcmd(CMD_TICK, 4'd0, '0, '0, 1'b0));

    for (int n = 0; n < 100; n++) begin
      while (pend_q.size() >= 2) @(posedge clk);
      if (n % 50 == 25) no_idle = ~no_idle;
      if ($urandom_range(0, 3) == 0 && n % 10 == 0)
        for (int i = 0; i < 8; i++) add_cmd(mkcmd(CMD_RELEASE, 4'(i), '0, '0, 1'b0));
      else add_cmd(random_cmd());
    end

    while (pend_q.size() > 0 || in_ch.valid || expect_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Run covered %0d commands, %0d result beats, %0d frames, %0d job starts.",
             sent, beats, ticks, starts);
    if (fails == 0 && expect_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
